// ----- hdl/rk4sc_pkg.sv -----
// shared types, codes, constants and helpers of the rk4 stage combiner
package rk4sc_pkg;

  localparam int NUM_STATES = 256;
  localparam int IDX_W      = $clog2(NUM_STATES);
  localparam int VAL_W      = 32;
  localparam int FAC_W      = 31;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = VAL_W + FAC_W + 1 - FRAC_W;
  localparam int SUM_W      = PROD_W + 3;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic [FAC_W-1:0]         fac_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [1:0]               op_t;
  typedef logic [1:0]               reg_idx_t;

  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_K2     = 2'd1;
  localparam op_t OP_K3     = 2'd2;
  localparam op_t OP_FINISH = 2'd3;

  localparam reg_idx_t REG_STEP_SIZE  = 2'd0;
  localparam reg_idx_t REG_HALF_STEP  = 2'd1;
  localparam reg_idx_t REG_SIXTH_STEP = 2'd2;
  localparam reg_idx_t REG_THIRD_STEP = 2'd3;

  localparam fac_t STEP_SIZE_RST  = 31'd65536;
  localparam fac_t HALF_STEP_RST  = 31'd32768;
  localparam fac_t SIXTH_STEP_RST = 31'd10923;
  localparam fac_t THIRD_STEP_RST = 31'd21845;

  // write request into the per-element stores
  typedef struct packed {
    logic origin_we;
    logic k1_we;
    logic k2_we;
    logic k3_we;
    idx_t addr;
    val_t origin_data;
    val_t deriv_data;
  } store_wr_t;

  // registered read data of the per-element stores
  typedef struct packed {
    val_t origin;
    val_t k1;
    val_t k2;
    val_t k3;
  } store_rd_t;

  // floor(f * v / 2^16)
  function automatic prod_t qmul(input fac_t f, input val_t v);
    logic signed [VAL_W+FAC_W:0] p;
    begin
      p = $signed({1'b0, f}) * v;
      qmul = p[VAL_W+FAC_W:FRAC_W];
    end
  endfunction

  function automatic val_t sat32(input sum_t s);
    begin
      if (s > sum_t'(32'sh7FFFFFFF)) begin
        sat32 = 32'sh7FFFFFFF;
      end else if (s < sum_t'(-64'sh80000000)) begin
        sat32 = 32'sh80000000;
      end else begin
        sat32 = s[VAL_W-1:0];
      end
    end
  endfunction

endpackage

// ----- hdl/rk4sc_store.sv -----
// per-element stores of the original state and the stage derivatives
module rk4sc_store (
  input  logic                  clk,
  input  rk4sc_pkg::store_wr_t  wr,
  input  logic                  rd_en,
  input  rk4sc_pkg::idx_t       rd_addr,
  output rk4sc_pkg::store_rd_t  rd
);
  import rk4sc_pkg::*;

  val_t origin_mem [NUM_STATES];
  val_t k1_mem     [NUM_STATES];
  val_t k2_mem     [NUM_STATES];
  val_t k3_mem     [NUM_STATES];

  always_ff @(posedge clk) begin
    if (wr.origin_we) begin
      origin_mem[wr.addr] <= wr.origin_data;
    end
    if (wr.k1_we) begin
      k1_mem[wr.addr] <= wr.deriv_data;
    end
    if (wr.k2_we) begin
      k2_mem[wr.addr] <= wr.deriv_data;
    end
    if (wr.k3_we) begin
      k3_mem[wr.addr] <= wr.deriv_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.origin <= origin_mem[rd_addr];
      rd.k1     <= k1_mem[rd_addr];
      rd.k2     <= k2_mem[rd_addr];
      rd.k3     <= k3_mem[rd_addr];
    end
  end

endmodule

// ----- hdl/rk4_stage_combiner_unit.sv -----
// top level of the rk4 stage combiner
// three-stage pipeline: store read, multiply, sum and saturate into the output register
// throughput: one item per cycle while out_stall does not hold the pipeline,
// set by the single read and write port of each store
// reset clears the pipeline valids and the start time and reloads the default step factors;
// the stores are not cleared and need no pass after reset
module rk4_stage_combiner_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  rk4sc_pkg::reg_idx_t   cfg_index,
  input  rk4sc_pkg::fac_t       cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rk4sc_pkg::op_t        op,
  input  rk4sc_pkg::idx_t       elem_index,
  input  rk4sc_pkg::val_t       state_value,
  input  rk4sc_pkg::val_t       deriv_value,
  input  rk4sc_pkg::val_t       step_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rk4sc_pkg::idx_t       out_index,
  output rk4sc_pkg::val_t       next_value,
  output rk4sc_pkg::val_t       eval_time,
  output logic                  is_final
);
  import rk4sc_pkg::*;

  fac_t step_size;
  fac_t half_step;
  fac_t sixth_step;
  fac_t third_step;
  val_t start_time;

  logic      accept;
  logic      rdy1;
  logic      rdy2;
  logic      rdy3;
  store_wr_t wr;
  store_rd_t rd;

  // stage 1: item fields, store data arrives from the read registers
  logic v1;
  op_t  op1;
  idx_t idx1;
  val_t x1;
  val_t d1;
  val_t t1;

  // stage 2: products
  logic  v2;
  op_t   op2;
  idx_t  idx2;
  val_t  x2;
  prod_t p0;
  prod_t p1;
  prod_t p2;
  prod_t p3;
  val_t  time2;

  val_t  x_sel;
  fac_t  fa;
  fac_t  ft;
  val_t  k1_op;
  val_t  k2_op;
  val_t  k3_op;
  sum_t  tsum;
  sum_t  vsum;

  assign rdy3     = !out_valid || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= STEP_SIZE_RST;
      half_step  <= HALF_STEP_RST;
      sixth_step <= SIXTH_STEP_RST;
      third_step <= THIRD_STEP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_SIZE:  step_size  <= cfg_data;
        REG_HALF_STEP:  half_step  <= cfg_data;
        REG_SIXTH_STEP: sixth_step <= cfg_data;
        REG_THIRD_STEP: third_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
    end else if (accept && op == OP_LOAD) begin
      start_time <= step_time;
    end
  end

  // store writes at acceptance; an item never reads a store it writes
  always_comb begin
    wr.origin_we   = accept && op == OP_LOAD;
    wr.k1_we       = accept && op == OP_LOAD;
    wr.k2_we       = accept && op == OP_K2;
    wr.k3_we       = accept && op == OP_K3;
    wr.addr        = elem_index;
    wr.origin_data = state_value;
    wr.deriv_data  = deriv_value;
  end

  rk4sc_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr (elem_index),
    .rd      (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op1  <= op;
      idx1 <= elem_index;
      x1   <= state_value;
      d1   <= deriv_value;
      t1   <= (op == OP_LOAD) ? step_time : start_time;
    end
  end

  always_comb begin
    x_sel = (op1 == OP_LOAD) ? x1 : rd.origin;
    k1_op = '0;
    k2_op = '0;
    k3_op = '0;
    case (op1)
      OP_LOAD: begin
        fa = half_step;
        ft = half_step;
      end
      OP_K2: begin
        fa = half_step;
        ft = half_step;
      end
      OP_K3: begin
        fa = step_size;
        ft = step_size;
      end
      OP_FINISH: begin
        fa    = sixth_step;
        ft    = step_size;
        k1_op = rd.k1;
        k2_op = rd.k2;
        k3_op = rd.k3;
      end
      default: begin
        fa = half_step;
        ft = half_step;
      end
    endcase
    tsum = sum_t'(t1) + sum_t'({1'b0, ft});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      op2   <= op1;
      idx2  <= idx1;
      x2    <= x_sel;
      p0    <= qmul(fa, d1);
      p1    <= qmul(sixth_step, k1_op);
      p2    <= qmul(third_step, k2_op);
      p3    <= qmul(third_step, k3_op);
      time2 <= sat32(tsum);
    end
  end

  assign vsum = sum_t'(x2) + sum_t'(p0) + sum_t'(p1) + sum_t'(p2) + sum_t'(p3);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      out_index  <= idx2;
      next_value <= sat32(vsum);
      eval_time  <= time2;
      is_final   <= (op2 == OP_FINISH);
    end
  end

endmodule
